// File: hw/rtl/lru_pkg.sv
// Shared constants and types for the LRU recency tracker.
`timescale 1ns / 1ps

package lru_pkg;

  // Defaults for the top-level parameters.
  localparam int CAPACITY_DEFAULT = 16;
  localparam int KEY_BITS_DEFAULT = 16;

  // Fixed widths of the transaction fields on the ports.
  localparam int FUNC_BITS     = 2;
  localparam int KEY_PORT_BITS = 16;
  localparam int STATUS_BITS   = 3;

  // Operation codes.
  localparam logic [FUNC_BITS-1:0] FN_TOUCH  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FN_EVICT  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_INSERTED    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_REMOVED     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_REMOVE_MISS = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_EVICTED     = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY       = 3'd6;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN     = 3'd7;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;  // Shift towards the tail up to the limit and load the front key.
    logic pull;  // Shift towards the head from the limit onwards.
  } lru_cmd_t;

endpackage

// File: hw/rtl/lru_cell.sv
// One slot of the recency chain: holds a key and moves it to or from its neighbours.
`timescale 1ns / 1ps

module lru_cell #(
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEFAULT,
  parameter int IDX_BITS = 4,
  parameter int CNT_BITS = 5,
  parameter int INDEX    = 0
) (
  input  logic                  clk,
  input  lru_pkg::lru_cmd_t     cmd,
  input  logic [IDX_BITS-1:0]   limit,
  input  logic [CNT_BITS-1:0]   count,
  input  logic [KEY_BITS-1:0]   front_key,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [KEY_BITS-1:0]   cmp_key,
  output logic [KEY_BITS-1:0]   cur_key,
  output logic                  match,
  output logic [KEY_BITS-1:0]   tail_key
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);
  localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(INDEX);
  localparam logic [CNT_BITS-1:0] MY_END = CNT_BITS'(INDEX + 1);

  logic [KEY_BITS-1:0] held_key;
  logic [KEY_BITS-1:0] held_key_next;
  logic                occupied;

  // A slot is occupied exactly when it lies below the held count.
  assign occupied = (MY_CNT < count);
  assign cur_key  = held_key;
  assign match    = occupied && (held_key == cmp_key);
  assign tail_key = (MY_END == count) ? held_key : '0;

  always_comb begin
    held_key_next = held_key;
    if (cmd.push) begin
      if (INDEX == 0) begin
        held_key_next = front_key;
      end else if (MY_IDX <= limit) begin
        held_key_next = left_key;
      end
    end else if (cmd.pull) begin
      if (MY_IDX >= limit) begin
        held_key_next = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_key <= held_key_next;
  end

endmodule

// File: hw/rtl/lru_recency_tracker.sv
// Top level of the LRU recency tracker: control, result register and the chain of cells.
`timescale 1ns / 1ps

// Keeps up to CAPACITY distinct keys in most-recent-first order in a chain of cells, slot 0
// being the most recent. A transaction is accepted in the idle phase; in the compare phase
// every cell compares its key with the request in parallel and the hit slot and tail key
// are registered; in the apply phase the cells on one side of the limit slot shift by one
// place (an eviction shifts none) and the result is loaded into the output register. A new
// transaction is taken once the previous one has been committed; the commit waits only
// while an earlier result is still stalled in the output register. No clearing pass is
// needed after reset: occupancy is derived from the held count, which reset clears.
module lru_recency_tracker #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS = lru_pkg::KEY_BITS_DEFAULT,
  localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lru_pkg::FUNC_BITS-1:0]     func,
  input  logic [lru_pkg::KEY_PORT_BITS-1:0] key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lru_pkg::STATUS_BITS-1:0]   status,
  output logic [lru_pkg::KEY_PORT_BITS-1:0] victim_key,
  output logic [CNT_BITS-1:0]               occupancy
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(CAPACITY);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CMP   = 2'd1;
  localparam logic [1:0] PH_APPLY = 2'd2;

  logic [1:0]                  phase;
  logic [lru_pkg::FUNC_BITS-1:0] op_func;
  logic [KEY_BITS-1:0]         op_key;
  logic [KEY_BITS-1:0]         key_ext;
  logic                        hit;
  logic [IDX_BITS-1:0]         slot;
  logic [KEY_BITS-1:0]         tail;
  logic [CNT_BITS-1:0]         count;

  logic [CNT_BITS-1:0]         count_next;
  logic [lru_pkg::STATUS_BITS-1:0] status_next;
  logic [KEY_BITS-1:0]         victim_next;
  logic [lru_pkg::KEY_PORT_BITS-1:0] victim_port;
  logic                        do_push;
  logic                        do_pull;
  logic [IDX_BITS-1:0]         limit;
  logic                        commit;
  lru_pkg::lru_cmd_t           cmd;

  logic [KEY_BITS-1:0]         cell_key  [CAPACITY];
  logic [KEY_BITS-1:0]         cell_tail [CAPACITY];
  logic [CAPACITY-1:0]         cell_match;
  logic [IDX_BITS-1:0]         slot_enc;
  logic [KEY_BITS-1:0]         tail_or;

  assign in_stall = (phase != PH_IDLE);
  assign commit   = (phase == PH_APPLY) && (!out_valid || !out_stall);
  assign cmd.push = commit && do_push;
  assign cmd.pull = commit && do_pull;

  // Key bits beyond KEY_BITS are dropped; a narrower port is zero-extended.
  always_comb begin
    key_ext = '0;
    for (int b = 0; b < KEY_BITS; b++) begin
      if (b < lru_pkg::KEY_PORT_BITS) begin
        key_ext[b] = key[b];
      end
    end
  end

  // Keys are distinct, so at most one cell matches and an OR of indices encodes it.
  always_comb begin
    slot_enc = '0;
    tail_or  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_match[i]) begin
        slot_enc = slot_enc | IDX_BITS'(i);
      end
      tail_or = tail_or | cell_tail[i];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = lru_pkg::ST_UNKNOWN;
    victim_next = '0;
    do_push     = 1'b0;
    do_pull     = 1'b0;
    limit       = slot;
    unique case (op_func)
      lru_pkg::FN_TOUCH: begin
        if (hit) begin
          do_push     = 1'b1;
          status_next = lru_pkg::ST_HIT;
        end else if (count == FULL_CNT) begin
          status_next = lru_pkg::ST_FULL;
        end else begin
          do_push     = 1'b1;
          limit       = count[IDX_BITS-1:0];
          count_next  = count + 1'b1;
          status_next = lru_pkg::ST_INSERTED;
        end
      end
      lru_pkg::FN_REMOVE: begin
        if (hit) begin
          do_pull     = 1'b1;
          count_next  = count - 1'b1;
          status_next = lru_pkg::ST_REMOVED;
        end else begin
          status_next = lru_pkg::ST_REMOVE_MISS;
        end
      end
      lru_pkg::FN_EVICT: begin
        if (count == '0) begin
          status_next = lru_pkg::ST_EMPTY;
        end else begin
          count_next  = count - 1'b1;
          victim_next = tail;
          status_next = lru_pkg::ST_EVICTED;
        end
      end
      default: begin
        status_next = lru_pkg::ST_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    victim_port = '0;
    for (int b = 0; b < lru_pkg::KEY_PORT_BITS; b++) begin
      if (b < KEY_BITS) begin
        victim_port[b] = victim_next[b];
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_in;
    logic [KEY_BITS-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_body
      assign left_in = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cell_key[i+1];
    end

    lru_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_BITS (IDX_BITS),
      .CNT_BITS (CNT_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .limit     (limit),
      .count     (count),
      .front_key (op_key),
      .left_key  (left_in),
      .right_key (right_in),
      .cmp_key   (op_key),
      .cur_key   (cell_key[i]),
      .match     (cell_match[i]),
      .tail_key  (cell_tail[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (in_valid) begin
            phase <= PH_CMP;
          end
        end
        PH_CMP: begin
          phase <= PH_APPLY;
        end
        PH_APPLY: begin
          if (commit) begin
            phase <= PH_IDLE;
            count <= count_next;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase

      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && in_valid) begin
      op_func <= func;
      op_key  <= key_ext;
    end
    if (phase == PH_CMP) begin
      hit  <= |cell_match;
      slot <= slot_enc;
      tail <= tail_or;
    end
    if (commit) begin
      status     <= status_next;
      victim_key <= victim_port;
      occupancy  <= count_next;
    end
  end

endmodule

// File: hw/rtl/lru_checker.sv
// Port-level checks for the LRU recency tracker and the bind that attaches them.
`timescale 1ns / 1ps

module lru_checker #(
  parameter int CAPACITY = lru_pkg::CAPACITY_DEFAULT,
  localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [lru_pkg::STATUS_BITS-1:0]   status,
  input logic [lru_pkg::KEY_PORT_BITS-1:0] victim_key,
  input logic [CNT_BITS-1:0]               occupancy
);

  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(CAPACITY);

  // One transaction is in flight at a time, so acceptance is followed by stall.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a transaction");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= FULL_CNT))
    else $error("occupancy beyond capacity");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lru_pkg::ST_EVICTED) |-> (victim_key == '0))
    else $error("victim key set on a result that is not an eviction");

  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status != lru_pkg::ST_EMPTY || occupancy == '0) &&
                   (status != lru_pkg::ST_FULL || occupancy == FULL_CNT)))
    else $error("empty or full status disagrees with occupancy");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 out_valid && status == lru_pkg::ST_INSERTED
      |-> (occupancy != '0))
    else $error("insertion reported with nothing held");

endmodule

bind lru_recency_tracker lru_checker #(.CAPACITY(CAPACITY)) u_lru_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .victim_key (victim_key),
  .occupancy  (occupancy)
);

// File: test/lru_recency_tracker_test.sv
// Self-checking testbench for the LRU recency tracker, with its own recency-order predictor.
`timescale 1ns / 1ps

module lru_recency_tracker_test;

  typedef logic [lru_pkg::FUNC_BITS-1:0]     func_t;
  typedef logic [lru_pkg::KEY_PORT_BITS-1:0] key_t;

  localparam int CAP        = lru_pkg::CAPACITY_DEFAULT;
  localparam int POOL_SIZE  = 24;
  localparam int RANDOM_OPS = 750;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 10;
  localparam int HOLD_OFF   = 40;

  // Selector code that names no operation.
  localparam func_t FN_RESERVED = 2'd3;

  typedef struct {
    func_t fn;
    key_t  k;
  } lru_op_t;

  typedef struct {
    logic [lru_pkg::STATUS_BITS-1:0] st;
    key_t                            victim;
    logic [4:0]                      occ;
  } lru_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  func_t                           func = lru_pkg::FN_TOUCH;
  key_t                            key = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [lru_pkg::STATUS_BITS-1:0] status;
  key_t                            victim_key;
  logic [4:0]                      occupancy;

  lru_op_t     op_queue[$];
  lru_result_t pending_results[$];

  // Shadow copy of the recency order, front at index zero.
  key_t        order_shadow[CAP];
  int unsigned held_shadow = 0;

  key_t        key_pool[POOL_SIZE];
  int unsigned total_ops = 0;
  int unsigned ops_accepted = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          hold_done_early = 1'b0;
  bit          hold_done_late = 1'b0;
  bit          failed = 1'b0;

  lru_recency_tracker #(
    .CAPACITY(CAP),
    .KEY_BITS(lru_pkg::KEY_BITS_DEFAULT)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .victim_key(victim_key),
    .occupancy (occupancy)
  );

  always #1 clk = ~clk;

  // Applies one operation to the shadow order and returns the result it gives.
  function automatic lru_result_t lru_apply(func_t fn, key_t k);
    lru_result_t r;
    int          hit;
    r.st     = lru_pkg::ST_UNKNOWN;
    r.victim = '0;
    hit      = -1;
    for (int i = 0; i < held_shadow; i++) begin
      if (hit < 0 && order_shadow[i] == k) hit = i;
    end
    case (fn)
      lru_pkg::FN_TOUCH: begin
        if (hit >= 0) begin
          for (int i = hit; i > 0; i--) order_shadow[i] = order_shadow[i-1];
          order_shadow[0] = k;
          r.st = lru_pkg::ST_HIT;
        end else if (held_shadow >= CAP) begin
          r.st = lru_pkg::ST_FULL;
        end else begin
          for (int i = held_shadow; i > 0; i--) order_shadow[i] = order_shadow[i-1];
          order_shadow[0] = k;
          held_shadow++;
          r.st = lru_pkg::ST_INSERTED;
        end
      end
      lru_pkg::FN_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < held_shadow; i++) order_shadow[i] = order_shadow[i+1];
          held_shadow--;
          r.st = lru_pkg::ST_REMOVED;
        end else begin
          r.st = lru_pkg::ST_REMOVE_MISS;
        end
      end
      lru_pkg::FN_EVICT: begin
        if (held_shadow == 0) begin
          r.st = lru_pkg::ST_EMPTY;
        end else begin
          held_shadow--;
          r.victim = order_shadow[held_shadow];
          r.st     = lru_pkg::ST_EVICTED;
        end
      end
      default: r.st = lru_pkg::ST_UNKNOWN;
    endcase
    r.occ = held_shadow[4:0];
    return r;
  endfunction

  // Idle percentages for the sender and the receiver in the current phase.
  function automatic int unsigned send_idle_pct();
    if (ops_accepted * 3 < total_ops) return 8;
    if (ops_accepted * 3 < total_ops * 2) return 84;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (ops_accepted * 3 < total_ops) return 84;
    if (ops_accepted * 3 < total_ops * 2) return 8;
    return 0;
  endfunction

  task automatic queue_op(func_t fn, key_t k);
    lru_op_t op;
    op.fn = fn;
    op.k  = k;
    op_queue.push_back(op);
  endtask

  // Driver: a new transaction is offered only once the previous one has gone.
  always @(posedge clk) begin
    lru_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(lru_apply(func, key));
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (op_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          op = op_queue.pop_front();
          in_valid <= 1'b1;
          func     <= op.fn;
          key      <= op.k;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and drives the receiver's stall.
  always @(posedge clk) begin
    lru_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d victim %h occupancy %0d",
                   $time, status, victim_key, occupancy);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            failed = 1'b1;
          end
          if (victim_key !== want.victim) begin
            $display("%0t: victim_key expected %h actual %h", $time, want.victim, victim_key);
            failed = 1'b1;
          end
          if (occupancy !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy);
            failed = 1'b1;
          end
        end
      end
      // Two long hold-offs let the block fill up and stall its input.
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!hold_done_early && total_ops > 0 && ops_accepted >= total_ops / 6) begin
        hold_done_early <= 1'b1;
        stall_left      <= HOLD_OFF;
        out_stall       <= 1'b1;
      end else if (!hold_done_late && total_ops > 0 && ops_accepted >= total_ops * 5 / 6) begin
        hold_done_late <= 1'b1;
        stall_left     <= HOLD_OFF;
        out_stall      <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
      end
    end
  end

  // Watchdog on cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lru_recency_tracker regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    int unsigned mode;
    func_t       fn;

    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom_range(0, 16'hFFFF));

    // Empty-store cases, the unknown selector, front and moved hits, then a fill past capacity.
    queue_op(lru_pkg::FN_EVICT, 16'h0000);
    queue_op(lru_pkg::FN_REMOVE, 16'h0000);
    queue_op(FN_RESERVED, 16'hFFFF);
    queue_op(lru_pkg::FN_TOUCH, 16'h0000);
    queue_op(lru_pkg::FN_TOUCH, 16'hFFFF);
    queue_op(lru_pkg::FN_TOUCH, 16'hFFFF);
    queue_op(lru_pkg::FN_TOUCH, 16'h0000);
    queue_op(lru_pkg::FN_REMOVE, 16'hFFFF);
    queue_op(lru_pkg::FN_EVICT, 16'hFFFF);
    for (int i = 0; i <= CAP; i++) begin
      queue_op(lru_pkg::FN_TOUCH, key_t'(32'h8000 ^ (32'h1111 * i)));
    end

    // Random part: bursts of fills, churn, drains and noise over a small key pool.
    while (op_queue.size() < RANDOM_OPS + 26) begin
      mode = $urandom_range(0, 9);
      n    = $urandom_range(4, 20);
      for (int j = 0; j < n; j++) begin
        case (mode)
          0, 1, 2, 3: queue_op(lru_pkg::FN_TOUCH, key_pool[$urandom_range(0, POOL_SIZE-1)]);
          4, 5: begin
            fn = ($urandom_range(0, 2) == 0) ? lru_pkg::FN_REMOVE : lru_pkg::FN_TOUCH;
            queue_op(fn, key_pool[$urandom_range(0, POOL_SIZE-1)]);
          end
          6, 7: queue_op(lru_pkg::FN_EVICT, key_t'($urandom_range(0, 16'hFFFF)));
          8:    queue_op(lru_pkg::FN_REMOVE, key_pool[$urandom_range(0, POOL_SIZE-1)]);
          default: queue_op(func_t'($urandom_range(0, 3)), key_t'($urandom_range(0, 16'hFFFF)));
        endcase
      end
    end
    total_ops = op_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (ops_accepted == total_ops);
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failed) begin
      $display("lru_recency_tracker regression: fail");
    end else begin
      $display("lru_recency_tracker regression: pass");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lru_pkg.sv
hw/rtl/lru_cell.sv
hw/rtl/lru_recency_tracker.sv
hw/rtl/lru_checker.sv
test/lru_recency_tracker_test.sv
